// File: sv/tgpg_pkg.sv
// Shared types, constants and functions of the text/graphics pixel generator.
`default_nettype none

package tgpg_pkg;

  localparam int CFG_AW = 5;
  localparam int CFG_DW = 32;

  localparam logic [1:0] REQ_PIXEL = 2'd0;
  localparam logic [1:0] REQ_VRAM_WR = 2'd1;
  localparam logic [1:0] REQ_GRP_WR = 2'd2;

  localparam logic [2:0] REG_TEXT_COLORS = 3'd0;
  localparam logic [2:0] REG_NAME_BASE = 3'd1;
  localparam logic [2:0] REG_PATTERN_BASE = 3'd2;
  localparam logic [2:0] REG_GFX_PAT_SEL = 3'd3;
  localparam logic [2:0] REG_GFX_COL_SEL = 3'd4;
  localparam logic [2:0] REG_MODE_BITS = 3'd5;
  localparam logic [2:0] REG_DISPLAY_ON = 3'd6;

  localparam logic [8:0] FRAME_W = 9'd288;
  localparam logic [7:0] FRAME_H = 8'd224;
  localparam logic [8:0] ACT_X_LO = 9'd16;
  localparam logic [8:0] ACT_X_HI = 9'd272;
  localparam logic [8:0] WIDE_X_LO = 9'd24;
  localparam logic [8:0] WIDE_X_HI = 9'd276;
  localparam logic [7:0] ACT_Y_LO = 8'd16;
  localparam logic [7:0] ACT_Y_HI = 8'd208;

  localparam logic [15:0] DIV6_RECIP = 16'd171;
  localparam int DIV6_SHIFT = 10;

  localparam logic [7:0] LEVEL_DIM = 8'hc0;
  localparam logic [7:0] LEVEL_FULL = 8'hff;

  typedef struct packed {
    logic [7:0] text_colors;
    logic [7:0] name_table_base;
    logic [7:0] pattern_base;
    logic [7:0] gfx_pat_sel;
    logic [7:0] gfx_col_sel;
    logic [7:0] mode_bits;
    logic       display_on;
  } cfg_t;

  typedef struct packed {
    logic ld_in;
    logic wr_vram;
    logic wr_grp;
    logic rd_name;
    logic ld_chr;
    logic rd_color;
    logic rd_pat;
    logic ld_direct;
    logic ld_pen;
  } cmd_t;

  typedef struct packed {
    logic direct;
    logic graphics;
  } status_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  function automatic logic [7:0] pen_level(input logic on, input logic bright);
    logic [7:0] lvl;
    lvl = 8'h00;
    if (on) begin
      lvl = bright ? LEVEL_FULL : LEVEL_DIM;
    end
    return lvl;
  endfunction

  function automatic rgb_t pen_to_rgb(input logic [3:0] pen);
    rgb_t c;
    c.red = pen_level(pen[3], pen[0]);
    c.green = pen_level(pen[1], pen[0]);
    c.blue = pen_level(pen[2], pen[0]);
    return c;
  endfunction

endpackage

`default_nettype wire

// File: sv/text_graphics_pixel_generator_top.sv
// Top level of the text/graphics pixel generator.
// A pixel in the border, off frame or with the display off gets its pen in state S_NAME; text
// pixels step through S_NAME, S_CHR, S_PAT and S_PEN, and graphics pixels add S_COLR after S_CHR.
// A new item is taken in the cycle its result is strobed; a write passes through S_WRV or S_WRG.
// Results cannot be stalled by the receiver. rst_n is synchronous and active low.
// Reset clears the configuration registers and the controller; video RAM and the color table are not cleared.
`default_nettype none

module text_graphics_pixel_generator_top (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  output logic                            busy,
  input  wire logic [1:0]                 in_req_type,
  input  wire logic [15:0]                in_address,
  input  wire logic [7:0]                 in_write_data,
  input  wire logic [8:0]                 in_pixel_x,
  input  wire logic [7:0]                 in_pixel_y,
  output logic                            out_strobe,
  output logic [3:0]                      out_pen_index,
  output logic [7:0]                      out_red_level,
  output logic [7:0]                      out_green_level,
  output logic [7:0]                      out_blue_level,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [tgpg_pkg::CFG_AW-1:0] paddr,
  input  wire logic [tgpg_pkg::CFG_DW-1:0] pwdata,
  output logic [tgpg_pkg::CFG_DW-1:0]      prdata,
  output logic                             pready
);
  import tgpg_pkg::*;

  cfg_t    cfg;
  cmd_t    cmd;
  status_t status;

  tgpg_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  tgpg_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .req_type   (in_req_type),
    .status     (status),
    .cmd        (cmd),
    .busy       (busy),
    .out_strobe (out_strobe)
  );

  tgpg_dp u_dp (
    .clk           (clk),
    .cfg           (cfg),
    .cmd           (cmd),
    .in_address    (in_address),
    .in_write_data (in_write_data),
    .in_pixel_x    (in_pixel_x),
    .in_pixel_y    (in_pixel_y),
    .status        (status),
    .pen_index     (out_pen_index),
    .red_level     (out_red_level),
    .green_level   (out_green_level),
    .blue_level    (out_blue_level)
  );

endmodule

`default_nettype wire

// File: sv/tgpg_cfg.sv
// APB register bank holding the display configuration.
`default_nettype none

module tgpg_cfg (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [tgpg_pkg::CFG_AW-1:0] paddr,
  input  wire logic [tgpg_pkg::CFG_DW-1:0] pwdata,
  output logic [tgpg_pkg::CFG_DW-1:0]      prdata,
  output logic                             pready,
  output tgpg_pkg::cfg_t                   cfg
);
  import tgpg_pkg::*;

  cfg_t       cfg_r;
  logic       wr_en;
  logic [2:0] reg_idx;

  assign reg_idx = paddr[CFG_AW-1:2];
  assign wr_en = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_TEXT_COLORS:  cfg_r.text_colors <= pwdata[7:0];
        REG_NAME_BASE:    cfg_r.name_table_base <= pwdata[7:0];
        REG_PATTERN_BASE: cfg_r.pattern_base <= pwdata[7:0];
        REG_GFX_PAT_SEL:  cfg_r.gfx_pat_sel <= pwdata[7:0];
        REG_GFX_COL_SEL:  cfg_r.gfx_col_sel <= pwdata[7:0];
        REG_MODE_BITS:    cfg_r.mode_bits <= pwdata[7:0];
        REG_DISPLAY_ON:   cfg_r.display_on <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      REG_TEXT_COLORS:  prdata[7:0] = cfg_r.text_colors;
      REG_NAME_BASE:    prdata[7:0] = cfg_r.name_table_base;
      REG_PATTERN_BASE: prdata[7:0] = cfg_r.pattern_base;
      REG_GFX_PAT_SEL:  prdata[7:0] = cfg_r.gfx_pat_sel;
      REG_GFX_COL_SEL:  prdata[7:0] = cfg_r.gfx_col_sel;
      REG_MODE_BITS:    prdata[7:0] = cfg_r.mode_bits;
      REG_DISPLAY_ON:   prdata[0] = cfg_r.display_on;
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// File: sv/tgpg_dp.sv
// Datapath: video RAM, group color table, address generation and pen lookup.
`default_nettype none

module tgpg_dp (
  input  wire logic           clk,
  input  wire tgpg_pkg::cfg_t cfg,
  input  wire tgpg_pkg::cmd_t cmd,
  input  wire logic [15:0]    in_address,
  input  wire logic [7:0]     in_write_data,
  input  wire logic [8:0]     in_pixel_x,
  input  wire logic [7:0]     in_pixel_y,
  output tgpg_pkg::status_t   status,
  output logic [3:0]          pen_index,
  output logic [7:0]          red_level,
  output logic [7:0]          green_level,
  output logic [7:0]          blue_level
);
  import tgpg_pkg::*;

  logic [7:0]  vram_r [65536];
  logic [7:0]  grp_tbl_r [32];

  logic [15:0] addr_r;
  logic [7:0]  data_r;
  logic [8:0]  x_r;
  logic [7:0]  y_r;
  logic [7:0]  rdata_r;
  logic [7:0]  grp_q_r;
  logic [7:0]  chr_r;
  logic [7:0]  colors_r;
  logic [2:0]  bit_r;
  logic [3:0]  pen_r;
  rgb_t        rgb_r;

  logic        graphics;
  logic        wide;
  logic [15:0] bank;
  logic [15:0] gen;
  logic [7:0]  ry;
  logic [4:0]  row;
  logic [2:0]  line;
  logic [1:0]  third;
  logic [7:0]  rx_n;
  logic [7:0]  rx_w;
  logic [15:0] prod6;
  logic [5:0]  wcol;
  logic [2:0]  wrem;
  logic [2:0]  bit_nxt;
  logic        x_out;
  logic [15:0] name_addr;
  logic [15:0] chr_line;
  logic [15:0] text_pat_addr;
  logic [15:0] gfx_col_addr;
  logic [15:0] gfx_pat_addr;
  logic [15:0] rd_addr;
  logic [3:0]  bg_pen;
  logic [7:0]  colors;
  logic [3:0]  pen_nxt;

  assign graphics = cfg.mode_bits[4];
  assign wide = ~cfg.mode_bits[4] & cfg.mode_bits[5];
  assign bank = {cfg.mode_bits[7:6], 14'b0};
  assign gen = {2'b0, cfg.pattern_base[3:1], 11'b0};
  assign bg_pen = cfg.text_colors[7:4];

  assign ry = 8'(y_r - ACT_Y_LO);
  assign row = ry[7:3];
  assign line = ry[2:0];
  assign third = row[4:3];

  assign rx_n = 8'(x_r - ACT_X_LO);
  assign rx_w = 8'(x_r - WIDE_X_LO);
  assign prod6 = 16'(16'(rx_w) * DIV6_RECIP);
  assign wcol = 6'(prod6 >> DIV6_SHIFT);
  assign wrem = 3'(rx_w - 8'({wcol, 1'b0} + {1'b0, wcol, 1'b0} + {wcol, 1'b0}));
  assign bit_nxt = wide ? 3'(3'd7 - wrem) : 3'(3'd7 - rx_n[2:0]);

  always_comb begin
    if (wide) begin
      name_addr = 16'(16'(wcol) + {5'b0, row, 6'b0} + {2'b0, cfg.name_table_base[3:1], 11'b0}
                      + bank);
    end else if (graphics) begin
      name_addr = 16'(16'(rx_n[7:3]) + {6'b0, row, 5'b0} + gen + bank);
    end else begin
      name_addr = 16'(16'(rx_n[7:3]) + {6'b0, row, 5'b0} + {2'b0, cfg.name_table_base[3:0], 10'b0}
                      + bank);
    end
  end

  assign chr_line = {5'b0, chr_r, line};
  assign text_pat_addr = 16'(chr_line + gen + bank);
  assign gfx_col_addr = 16'(chr_line + {2'b0, ~cfg.gfx_col_sel[3], 13'b0} + bank
                            + {3'b0, third, 11'b0});
  assign gfx_pat_addr = 16'(chr_line + {2'b0, ~cfg.gfx_pat_sel[3], 13'b0} + bank
                            + {3'b0, third, 11'b0});

  always_comb begin
    priority if (cmd.rd_name) begin
      rd_addr = name_addr;
    end else if (cmd.rd_color) begin
      rd_addr = gfx_col_addr;
    end else if (graphics) begin
      rd_addr = gfx_pat_addr;
    end else begin
      rd_addr = text_pat_addr;
    end
  end

  always_comb begin
    if (wide) begin
      x_out = (x_r < WIDE_X_LO) || (x_r >= WIDE_X_HI);
    end else begin
      x_out = (x_r < ACT_X_LO) || (x_r >= ACT_X_HI);
    end
  end

  assign status.direct = ~cfg.display_on || (x_r >= FRAME_W) || (y_r >= FRAME_H)
                         || (y_r < ACT_Y_LO) || (y_r >= ACT_Y_HI) || x_out;
  assign status.graphics = graphics;

  always_comb begin
    if (graphics) begin
      colors = colors_r;
    end else if (wide) begin
      colors = cfg.text_colors;
    end else begin
      colors = grp_q_r;
    end
  end

  always_comb begin
    if (cmd.ld_direct) begin
      pen_nxt = (~cfg.display_on || (x_r >= FRAME_W) || (y_r >= FRAME_H)) ? 4'd0 : bg_pen;
    end else begin
      pen_nxt = rdata_r[bit_r] ? colors[3:0] : colors[7:4];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_vram) begin
      vram_r[addr_r] <= data_r;
    end
    rdata_r <= vram_r[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_grp) begin
      grp_tbl_r[addr_r[4:0]] <= data_r;
    end
    grp_q_r <= grp_tbl_r[chr_r[7:3]];
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_in) begin
      addr_r <= in_address;
      data_r <= in_write_data;
      x_r <= in_pixel_x;
      y_r <= in_pixel_y;
    end
    if (cmd.rd_name) begin
      bit_r <= bit_nxt;
    end
    if (cmd.ld_chr) begin
      chr_r <= rdata_r;
    end
    if (cmd.rd_pat) begin
      colors_r <= rdata_r;
    end
    if (cmd.ld_direct || cmd.ld_pen) begin
      pen_r <= pen_nxt;
      rgb_r <= pen_to_rgb(pen_nxt);
    end
  end

  assign pen_index = pen_r;
  assign red_level = rgb_r.red;
  assign green_level = rgb_r.green;
  assign blue_level = rgb_r.blue;

endmodule

`default_nettype wire

// File: sv/tgpg_ctrl.sv
// Controller state machine sequencing writes and the pixel lookup reads.
`default_nettype none

module tgpg_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [1:0]        req_type,
  input  wire tgpg_pkg::status_t status,
  output tgpg_pkg::cmd_t         cmd,
  output logic                   busy,
  output logic                   out_strobe
);
  import tgpg_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WRV,
    S_WRG,
    S_NAME,
    S_CHR,
    S_COLR,
    S_PAT,
    S_PEN
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   strobe_r;
  logic   strobe_nxt;
  logic   accept;

  assign busy = (state_r != S_IDLE);
  assign accept = start & ~busy;
  assign out_strobe = strobe_r;

  always_comb begin
    cmd = '0;
    state_nxt = state_r;
    strobe_nxt = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.ld_in = 1'b1;
          unique case (req_type)
            REQ_PIXEL:   state_nxt = S_NAME;
            REQ_VRAM_WR: state_nxt = S_WRV;
            REQ_GRP_WR:  state_nxt = S_WRG;
            default:     state_nxt = S_IDLE;
          endcase
        end
      end
      S_WRV: begin
        cmd.wr_vram = 1'b1;
        state_nxt = S_IDLE;
      end
      S_WRG: begin
        cmd.wr_grp = 1'b1;
        state_nxt = S_IDLE;
      end
      S_NAME: begin
        if (status.direct) begin
          cmd.ld_direct = 1'b1;
          strobe_nxt = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          cmd.rd_name = 1'b1;
          state_nxt = S_CHR;
        end
      end
      S_CHR: begin
        cmd.ld_chr = 1'b1;
        state_nxt = status.graphics ? S_COLR : S_PAT;
      end
      S_COLR: begin
        cmd.rd_color = 1'b1;
        state_nxt = S_PAT;
      end
      S_PAT: begin
        cmd.rd_pat = 1'b1;
        state_nxt = S_PEN;
      end
      S_PEN: begin
        cmd.ld_pen = 1'b1;
        strobe_nxt = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      strobe_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  a_strobe_in_idle: assert property (@(posedge clk) disable iff (!rst_n)
    strobe_r |-> (state_r == S_IDLE))
    else $error("result strobe outside idle state");

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    strobe_r |=> !strobe_r)
    else $error("result strobe held for more than one cycle");

  a_write_no_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (req_type == REQ_VRAM_WR || req_type == REQ_GRP_WR)) |=> ##1 !strobe_r)
    else $error("write transfer produced a result");

  a_strobe_source: assert property (@(posedge clk) disable iff (!rst_n)
    strobe_r |-> ($past(state_r) == S_NAME || $past(state_r) == S_PEN))
    else $error("result strobe from an unexpected state");

endmodule

`default_nettype wire

// File: verif/tb_text_graphics_pixel_generator_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for the text/graphics pixel generator: directed edges, then random traffic.
module tb_text_graphics_pixel_generator_top;
  import tgpg_pkg::*;

  localparam logic [1:0] REQ_NONE = 2'd3;
  localparam int SETTLE_CYCLES = 8;
  localparam int STALL_LIMIT = 1000;
  localparam int ITEM_TARGET = 450;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] addr;
    logic [7:0]  data;
    logic [8:0]  px;
    logic [7:0]  py;
  } request_t;

  typedef struct packed {
    logic [3:0] pen;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [1:0] in_req_type = '0;
  logic [15:0] in_address = '0;
  logic [7:0] in_write_data = '0;
  logic [8:0] in_pixel_x = '0;
  logic [7:0] in_pixel_y = '0;
  logic out_strobe;
  logic [3:0] out_pen_index;
  logic [7:0] out_red_level;
  logic [7:0] out_green_level;
  logic [7:0] out_blue_level;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [CFG_AW-1:0] paddr = '0;
  logic [CFG_DW-1:0] pwdata = '0;
  logic [CFG_DW-1:0] prdata;
  logic pready;

  cfg_t regs = '0;
  logic [7:0] vram_model [65536];
  logic [7:0] color_model [32];
  logic [7:0] plan_vram [65536];
  bit plan_vram_set [65536];
  bit plan_color_set [32];
  logic [15:0] touched_addrs [$];
  request_t pending_items [$];
  pixel_t expected_pixels [$];
  request_t held_item;
  int counted_items = 0;
  int mismatches = 0;
  int gap_left = 0;
  int idle_cycles = 0;
  bit gaps_on = 1'b1;

  text_graphics_pixel_generator_top u_top (.*);

  initial begin
    forever #10 clk = ~clk;
  end

  task automatic report(input string what);
    mismatches++;
    $display("%0t: %s", $time, what);
  endtask

  function automatic request_t blank_item(input logic [1:0] kind);
    request_t r;
    r.kind = kind;
    r.addr = 16'($urandom);
    r.data = 8'($urandom);
    r.px = 9'($urandom);
    r.py = 8'($urandom);
    return r;
  endfunction

  function automatic void enqueue(input request_t r);
    if (r.kind == REQ_VRAM_WR) begin
      plan_vram[r.addr] = r.data;
      plan_vram_set[r.addr] = 1'b1;
      touched_addrs.push_back(r.addr);
    end else if (r.kind == REQ_GRP_WR) begin
      plan_color_set[r.addr[4:0]] = 1'b1;
    end
    if (r.kind != REQ_NONE) counted_items++;
    pending_items.push_back(r);
  endfunction

  // In planning mode, any entry not yet written gets a write transfer queued ahead of the pixel.
  function automatic logic [7:0] vram_byte(input logic [15:0] a, input bit plan);
    request_t w;
    if (!plan) return vram_model[a];
    if (!plan_vram_set[a]) begin
      w = blank_item(REQ_VRAM_WR);
      w.addr = a;
      enqueue(w);
    end
    return plan_vram[a];
  endfunction

  function automatic logic [7:0] group_byte(input logic [4:0] idx, input bit plan);
    request_t w;
    if (plan && !plan_color_set[idx]) begin
      w = blank_item(REQ_GRP_WR);
      w.addr = {11'($urandom), idx};
      enqueue(w);
    end
    return color_model[idx];
  endfunction

  function automatic logic [3:0] pen_at(input logic [8:0] px, input logic [7:0] py,
                                        input bit plan);
    int unsigned bank, gen, row, line, rx, col, bit_pos, third;
    logic [15:0] cbase, pbase;
    logic [7:0] chr, pat, colors;
    bank = int'(regs.mode_bits[7:6]) << 14;
    gen = int'(regs.pattern_base[3:1]) << 11;
    if (py < 16 || py >= 208) return regs.text_colors[7:4];
    row = (py - 16) >> 3;
    line = (py - 16) & 7;
    if (!regs.mode_bits[4] && regs.mode_bits[5]) begin
      if (px < 24 || px >= 276) return regs.text_colors[7:4];
      rx = px - 24;
      col = rx / 6;
      bit_pos = 7 - rx % 6;
      chr = vram_byte(16'(col + row * 64 + (int'(regs.name_table_base[3:1]) << 11) + bank),
                      plan);
      pat = vram_byte(16'((int'(chr) << 3) + line + gen + bank), plan);
      colors = regs.text_colors;
    end else begin
      if (px < 16 || px >= 272) return regs.text_colors[7:4];
      rx = px - 16;
      col = rx >> 3;
      bit_pos = 7 - (rx & 7);
      if (regs.mode_bits[4]) begin
        third = (row >> 3) << 11;
        cbase = 16'((regs.gfx_col_sel[3] ? 0 : 8192) + bank + third);
        pbase = 16'((regs.gfx_pat_sel[3] ? 0 : 8192) + bank + third);
        chr = vram_byte(16'(col + row * 32 + gen + bank), plan);
        colors = vram_byte(16'((int'(chr) << 3) + line + cbase), plan);
        pat = vram_byte(16'((int'(chr) << 3) + line + pbase), plan);
      end else begin
        chr = vram_byte(16'(col + row * 32 + (int'(regs.name_table_base[3:0]) << 10) + bank),
                        plan);
        pat = vram_byte(16'((int'(chr) << 3) + line + gen + bank), plan);
        colors = group_byte(chr[7:3], plan);
      end
    end
    return pat[bit_pos] ? colors[3:0] : colors[7:4];
  endfunction

  function automatic pixel_t shade(input logic [3:0] pen);
    pixel_t p;
    logic [23:0] rgb;
    case (pen)
      4'd2: rgb = 24'h00c000;
      4'd3: rgb = 24'h00ff00;
      4'd4: rgb = 24'h0000c0;
      4'd5: rgb = 24'h0000ff;
      4'd6: rgb = 24'h00c0c0;
      4'd7: rgb = 24'h00ffff;
      4'd8: rgb = 24'hc00000;
      4'd9: rgb = 24'hff0000;
      4'd10: rgb = 24'hc0c000;
      4'd11: rgb = 24'hffff00;
      4'd12: rgb = 24'hc000c0;
      4'd13: rgb = 24'hff00ff;
      4'd14: rgb = 24'hc0c0c0;
      4'd15: rgb = 24'hffffff;
      default: rgb = 24'h000000;
    endcase
    p.pen = pen;
    {p.red, p.green, p.blue} = rgb;
    return p;
  endfunction

  function automatic void apply_request(input request_t r);
    case (r.kind)
      REQ_VRAM_WR: vram_model[r.addr] = r.data;
      REQ_GRP_WR: color_model[r.addr[4:0]] = r.data;
      REQ_PIXEL: begin
        if (!regs.display_on || r.px >= 288 || r.py >= 224) begin
          expected_pixels.push_back(shade(4'd0));
        end else begin
          expected_pixels.push_back(shade(pen_at(r.px, r.py, 1'b0)));
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void plan_pixel(input int unsigned x, input int unsigned y);
    request_t r;
    r = blank_item(REQ_PIXEL);
    r.px = 9'(x);
    r.py = 8'(y);
    if (regs.display_on && x < 288 && y < 224) void'(pen_at(r.px, r.py, 1'b1));
    enqueue(r);
  endfunction

  function automatic void plan_edges(input int unsigned lo, input int unsigned hi);
    plan_pixel(lo - 1, 16);
    plan_pixel(lo, 16);
    plan_pixel(hi - 1, 207);
    plan_pixel(hi, 207);
    plan_pixel(lo, 15);
    plan_pixel(lo, 208);
  endfunction

  // Most pixels fall in the drawn area, many of them in one small window so that table
  // entries are shared and later overwritten.
  function automatic void random_phase(input int n);
    int unsigned lo, hi, fx, fy, pick;
    request_t r;
    lo = (regs.mode_bits[5:4] == 2'b10) ? 24 : 16;
    hi = (lo == 24) ? 276 : 272;
    fx = $urandom_range(lo, hi - 24);
    fy = $urandom_range(16, 200);
    repeat (n) begin
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
        plan_pixel(fx + $urandom_range(0, 23), fy + $urandom_range(0, 7));
      end else if (pick < 60) begin
        plan_pixel($urandom_range(lo, hi - 1), $urandom_range(16, 207));
      end else if (pick < 70) begin
        plan_pixel($urandom_range(0, 287), $urandom_range(0, 223));
      end else if (pick < 75) begin
        plan_pixel($urandom_range(0, 511), $urandom_range(224, 255));
      end else if (pick < 78) begin
        plan_pixel($urandom_range(288, 511), $urandom_range(0, 255));
      end else if (pick < 90) begin
        r = blank_item(REQ_VRAM_WR);
        if (touched_addrs.size() != 0 && $urandom_range(0, 1) == 0) begin
          r.addr = touched_addrs[$urandom_range(0, touched_addrs.size() - 1)];
        end
        enqueue(r);
      end else if (pick < 96) begin
        enqueue(blank_item(REQ_GRP_WR));
      end else begin
        enqueue(blank_item(REQ_NONE));
      end
    end
  endfunction

  task automatic cfg_write(input logic [2:0] idx, input logic [31:0] value);
    logic [7:0] keep;
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_TEXT_COLORS: regs.text_colors = value[7:0];
      REG_NAME_BASE: regs.name_table_base = value[7:0];
      REG_PATTERN_BASE: regs.pattern_base = value[7:0];
      REG_GFX_PAT_SEL: regs.gfx_pat_sel = value[7:0];
      REG_GFX_COL_SEL: regs.gfx_col_sel = value[7:0];
      REG_MODE_BITS: regs.mode_bits = value[7:0];
      REG_DISPLAY_ON: regs.display_on = value[0];
      default: ;
    endcase
    keep = (idx == REG_DISPLAY_ON) ? 8'h01 : 8'hff;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if ((prdata[7:0] & keep) !== (value[7:0] & keep)) begin
      report($sformatf("register %0d reads %h, expected %h", idx, prdata[7:0] & keep,
                       value[7:0] & keep));
    end
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic apply_config(input logic [31:0] colors, name_base, pat_base, pat_sel, col_sel,
                              mode, on);
    cfg_write(REG_TEXT_COLORS, colors);
    cfg_write(REG_NAME_BASE, name_base);
    cfg_write(REG_PATTERN_BASE, pat_base);
    cfg_write(REG_GFX_PAT_SEL, pat_sel);
    cfg_write(REG_GFX_COL_SEL, col_sel);
    cfg_write(REG_MODE_BITS, mode);
    cfg_write(REG_DISPLAY_ON, on);
  endtask

  task automatic wait_drained();
    do @(posedge clk);
    while (pending_items.size() != 0 || start || expected_pixels.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  always @(posedge clk) begin : drive_proc
    if (!rst_n) begin
      start <= 1'b0;
      gap_left = 0;
    end else if (!(start && busy)) begin
      if (start) apply_request(held_item);
      if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (pending_items.size() != 0) begin
        held_item = pending_items.pop_front();
        in_req_type <= held_item.kind;
        in_address <= held_item.addr;
        in_write_data <= held_item.data;
        in_pixel_x <= held_item.px;
        in_pixel_y <= held_item.py;
        start <= 1'b1;
        if (gaps_on && $urandom_range(0, 3) == 0) gap_left = $urandom_range(1, 12);
      end else begin
        start <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : check_proc
    pixel_t want;
    if (rst_n && out_strobe) begin
      if (expected_pixels.size() == 0) begin
        report("pixel result with none pending");
      end else begin
        want = expected_pixels.pop_front();
        if (out_pen_index !== want.pen) begin
          report($sformatf("pen %0d, expected %0d", out_pen_index, want.pen));
        end
        if (out_red_level !== want.red) begin
          report($sformatf("red %h, expected %h", out_red_level, want.red));
        end
        if (out_green_level !== want.green) begin
          report($sformatf("green %h, expected %h", out_green_level, want.green));
        end
        if (out_blue_level !== want.blue) begin
          report($sformatf("blue %h, expected %h", out_blue_level, want.blue));
        end
      end
    end
  end

  always @(posedge clk) begin : watchdog_proc
    if (!rst_n || (start && !busy) || out_strobe || (psel && penable)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("[text_graphics_pixel_generator_top] ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    logic [31:0] mode;
    int phase;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    plan_pixel(0, 0);
    plan_pixel(287, 223);
    plan_pixel(511, 255);
    enqueue(blank_item(REQ_NONE));
    wait_drained();

    mode = $urandom;
    mode[5:4] = 2'b00;
    apply_config($urandom, $urandom, $urandom, $urandom, $urandom, mode, 32'd1);
    plan_edges(16, 272);
    plan_pixel(288, 0);
    plan_pixel(0, 224);
    plan_pixel(511, 255);
    wait_drained();

    mode[5:4] = 2'b10;
    apply_config($urandom, $urandom, $urandom, $urandom, $urandom, mode, 32'd1);
    plan_edges(24, 276);
    wait_drained();

    mode[4] = 1'b1;
    apply_config($urandom, $urandom, $urandom, $urandom, $urandom, mode, 32'd1);
    plan_edges(16, 272);

    phase = 0;
    while (counted_items < ITEM_TARGET) begin
      wait_drained();
      gaps_on = counted_items < ITEM_TARGET - 120 && $urandom_range(0, 3) != 0;
      case (phase)
        0: apply_config('1, '1, '1, '1, '1, '1, '1);
        1: apply_config('0, '0, '0, '0, '0, '0, 32'd1);
        default: begin
          mode = $urandom;
          case ($urandom_range(0, 2))
            0: mode[5:4] = 2'b00;
            1: mode[5:4] = 2'b10;
            default: mode[4] = 1'b1;
          endcase
          apply_config($urandom, $urandom, $urandom, $urandom, $urandom, mode,
                       {31'($urandom), $urandom_range(0, 7) != 0});
        end
      endcase
      random_phase(40);
      phase++;
    end

    wait_drained();
    if (mismatches == 0) begin
      $display("[text_graphics_pixel_generator_top] OK");
    end else begin
      $display("[text_graphics_pixel_generator_top] ERROR");
    end
    $finish;
  end

endmodule

// File: files.f
sv/tgpg_pkg.sv
sv/tgpg_cfg.sv
sv/tgpg_dp.sv
sv/tgpg_ctrl.sv
sv/text_graphics_pixel_generator_top.sv
verif/tb_text_graphics_pixel_generator_top.sv
